FILE: hw/rtl/range_count_equal_and_assign_assert.svh
// assertion macros for the range count block
`ifndef RANGE_COUNT_EQUAL_AND_ASSIGN_ASSERT_SVH
`define RANGE_COUNT_EQUAL_AND_ASSIGN_ASSERT_SVH
`ifndef ASSERT_OFF
`define RCA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RCA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RCA_ASSERT(label, prop, msg)
`define RCA_ASSERT_RST(label, prop, msg)
`endif
`endif

FILE: hw/rtl/rca_pkg.sv
package rca_pkg;
  localparam int unsigned ArrayDepth = 1024;
  localparam int unsigned BlockSize  = 32;
  localparam int unsigned NumBlocks  = (ArrayDepth + BlockSize - 1) / BlockSize;
  localparam int unsigned IdxW  = 10;
  localparam int unsigned BlkW  = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int unsigned OffW  = $clog2(BlockSize);
  localparam int unsigned AddrW = $clog2(ArrayDepth);
  localparam int unsigned ValW  = 32;
  localparam int unsigned CntW  = 11;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdRange = 1'b1;
endpackage

FILE: hw/rtl/range_count_equal_and_assign.sv
// range count-equal-and-assign over a 1024 x 32 block-tagged element memory
// load: block, read and write states, then back in idle; a tagged block is pushed down first
// range: each block visited passes the block state and each element walked a read and a write
//   state; a tagged edge block is pushed down first; a tagged whole block is answered from its tag
// the count is registered in the done state; input stalls until the count is taken
// reset clears the tag valid bits, the state and output valid; memories and data are not cleared
`include "range_count_equal_and_assign_assert.svh"
module range_count_equal_and_assign import rca_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    command_i,
  input  logic [IdxW-1:0]         range_lo_i,
  input  logic [IdxW-1:0]         range_hi_i,
  input  logic signed [ValW-1:0]  value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CntW-1:0]         equal_count_o
);

  // sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StBlock = 3'd1; // decide how to treat the current block
  localparam logic [2:0] StRead  = 3'd2; // element read issued
  localparam logic [2:0] StWrite = 3'd3; // compare and write back
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic                cmd_q;
  logic [IdxW:0]       lo_q, hi_q;       // clipped range, one bit wider for compares
  logic [ValW-1:0]     val_q;
  logic [BlkW-1:0]     blk_q;            // block being processed
  logic [IdxW:0]       idx_q;            // element index being walked
  logic [IdxW:0]       span_hi_q;        // last element of current walk
  logic                push_q;           // walk is a pure tag push-down
  logic [ValW-1:0]     push_val_q;
  logic                tag_after_q;      // set tag when walk ends (untagged inner block)
  logic [CntW-1:0]     cnt_q;
  logic                out_valid_q;
  logic [CntW-1:0]     out_cnt_q;

  // storage
  logic [ValW-1:0]     elem_mem [ArrayDepth];
  logic [ValW-1:0]     tag_val  [NumBlocks];
  logic [NumBlocks-1:0] tag_vld_q;
  logic [ValW-1:0]     rd_data_q;

  logic                acc_in;
  assign in_stall_o = (state_q != StIdle) || out_valid_q;
  assign acc_in = in_valid_i && !in_stall_o;

  // block-relative bounds
  logic [IdxW:0] blk_base, blk_last;
  assign blk_base = (IdxW+1)'(blk_q) * (IdxW+1)'(BlockSize);
  assign blk_last = blk_base + (IdxW+1)'(BlockSize - 1);

  logic [BlkW-1:0] blo, bhi;
  assign blo = BlkW'(lo_q / BlockSize);
  assign bhi = BlkW'(hi_q / BlockSize);
  logic inner;
  assign inner = (blk_q != blo) && (blk_q != bhi);

  logic [IdxW:0] seg_lo, seg_hi;
  assign seg_lo = (blk_q == blo) ? lo_q : blk_base;
  assign seg_hi = (blk_q == bhi) ? hi_q : blk_last;

  logic [IdxW:0] hi_clip;
  assign hi_clip = ({1'b0, range_hi_i} >= (IdxW+1)'(ArrayDepth)) ?
                   (IdxW+1)'(ArrayDepth - 1) : {1'b0, range_hi_i};

  logic          mem_we;
  logic [ValW-1:0] mem_wd;
  logic          eq;
  assign eq = (rd_data_q == val_q);

  always_comb begin
    mem_we = 1'b0;
    mem_wd = push_q ? push_val_q : val_q;
    if (state_q == StWrite) mem_we = 1'b1;
    if (state_q == StWrite && cmd_q == CmdLoad && !push_q) mem_wd = val_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) elem_mem[idx_q[AddrW-1:0]] <= mem_wd;
    rd_data_q <= elem_mem[idx_q[AddrW-1:0]];
  end

  logic          tag_we;
  always_comb tag_we = (state_q == StBlock) && cmd_q == CmdRange && inner &&
                       tag_vld_q[blk_q];
  always_ff @(posedge clk_i) begin
    if (tag_we || (state_q == StWrite && tag_after_q && idx_q == span_hi_q))
      tag_val[blk_q] <= val_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (acc_in) state_d = StBlock;
      StBlock: begin
        if (cmd_q == CmdLoad && lo_q >= (IdxW+1)'(ArrayDepth)) state_d = StIdle;
        else if (cmd_q == CmdRange && lo_q > hi_q) state_d = StDone;
        else if (tag_vld_q[blk_q] && !inner) state_d = StRead; // push-down walk
        else if (cmd_q == CmdRange && inner && tag_vld_q[blk_q]) begin
          state_d = (blk_q == bhi) ? StDone : StBlock;
        end else state_d = StRead;
      end
      StRead:  state_d = StWrite;
      StWrite: begin
        if (idx_q != span_hi_q) state_d = StRead;
        else if (push_q) state_d = StBlock;
        else if (cmd_q == CmdLoad) state_d = StIdle;
        else if (blk_q == bhi) state_d = StDone;
        else state_d = StBlock;
      end
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tag_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == StDone) out_valid_q <= 1'b1;
      if (state_q == StBlock && tag_vld_q[blk_q] && !inner &&
          !(cmd_q == CmdLoad && lo_q >= (IdxW+1)'(ArrayDepth)) &&
          !(cmd_q == CmdRange && lo_q > hi_q))
        tag_vld_q[blk_q] <= 1'b0;
      if (state_q == StWrite && tag_after_q && idx_q == span_hi_q)
        tag_vld_q[blk_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      cmd_q <= command_i;
      lo_q  <= {1'b0, range_lo_i};
      hi_q  <= (command_i == CmdLoad) ? {1'b0, range_lo_i} : hi_clip;
      val_q <= value_i;
      blk_q <= BlkW'(range_lo_i / BlockSize);
      cnt_q <= '0;
    end
    if (state_q == StBlock) begin
      push_q      <= 1'b0;
      tag_after_q <= 1'b0;
      push_val_q  <= tag_val[blk_q];
      if (tag_vld_q[blk_q] && !inner) begin
        push_q    <= 1'b1;
        idx_q     <= blk_base;
        span_hi_q <= (blk_last >= (IdxW+1)'(ArrayDepth)) ?
                     (IdxW+1)'(ArrayDepth - 1) : blk_last;
      end else if (cmd_q == CmdLoad) begin
        idx_q     <= lo_q;
        span_hi_q <= lo_q;
      end else if (inner && tag_vld_q[blk_q]) begin
        if (tag_val[blk_q] == val_q) cnt_q <= cnt_q + CntW'(BlockSize);
        blk_q <= blk_q + BlkW'(1);
      end else begin
        idx_q       <= seg_lo;
        span_hi_q   <= seg_hi;
        tag_after_q <= inner;
      end
    end
    if (state_q == StWrite) begin
      idx_q <= idx_q + (IdxW+1)'(1);
      if (!push_q && cmd_q == CmdRange && eq) cnt_q <= cnt_q + CntW'(1);
      if (idx_q == span_hi_q && !push_q && cmd_q == CmdRange && blk_q != bhi)
        blk_q <= blk_q + BlkW'(1);
    end
    if (state_q == StDone) out_cnt_q <= cnt_q;
  end

  assign out_valid_o   = out_valid_q;
  assign equal_count_o = out_cnt_q;

  `RCA_ASSERT_RST(a_out_reset, !rst_ni |=> !out_valid_o, "output valid after reset")
  `RCA_ASSERT(a_busy_stall, (state_q != StIdle) |-> in_stall_o, "accepted while busy")
  `RCA_ASSERT(a_done_once, (state_q == StDone) |=> (state_q == StIdle), "done not one cycle")
  `RCA_ASSERT(a_wr_after_rd, (state_q == StWrite) |-> $past(state_q) == StRead,
              "write without read")
endmodule

FILE: sim/range_count_equal_and_assign_tb.sv
module range_count_equal_and_assign_tb;
  import rca_pkg::*;

  // one pending transaction for the input side
  typedef struct {
    logic                   cmd;
    logic [IdxW-1:0]        lo;
    logic [IdxW-1:0]        hi;
    logic signed [ValW-1:0] val;
    bit                     drain_first;  // wait until every count has come back
  } req_t;

  localparam int unsigned NumItems   = 1850;
  localparam int unsigned QuietTail  = 150;
  localparam int unsigned IdleLimit  = 20000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned HoldAtItem = 300;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   command_i = CmdLoad;
  logic [IdxW-1:0]        range_lo_i = '0;
  logic [IdxW-1:0]        range_hi_i = '0;
  logic signed [ValW-1:0] value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [CntW-1:0]        equal_count_o;

  range_count_equal_and_assign uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .range_lo_i    (range_lo_i),
    .range_hi_i    (range_hi_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .equal_count_o (equal_count_o)
  );

  // clock and a single reset at the start
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  req_t            pending_q[$];
  logic [CntW-1:0] count_q[$];
  bit              written[ArrayDepth];  // generator view: element holds a defined value
  int              errors = 0;
  int              accepted_items = 0;

  // shadow of the block: element values and per-block lazy tags
  logic [ValW-1:0] shadow_mem[ArrayDepth];
  logic [ValW-1:0] shadow_tag_val[NumBlocks];
  bit              shadow_tag_on[NumBlocks];

  function automatic void flush_tag(int unsigned blk);
    if (!shadow_tag_on[blk]) return;
    for (int unsigned k = 0; k < BlockSize; k++)
      if (blk * BlockSize + k < ArrayDepth) shadow_mem[blk * BlockSize + k] = shadow_tag_val[blk];
    shadow_tag_on[blk] = 1'b0;
  endfunction

  // count matches within one block, then overwrite
  function automatic int unsigned count_span(int unsigned lo, int unsigned hi,
                                             logic [ValW-1:0] v);
    int unsigned n = 0;
    flush_tag(lo / BlockSize);
    for (int unsigned i = lo; i <= hi && i < ArrayDepth; i++) begin
      if (shadow_mem[i] == v) n++;
      shadow_mem[i] = v;
    end
    return n;
  endfunction

  // apply one transaction to the shadow; returns 1 when a count is produced
  function automatic bit predict_count(req_t r, output logic [CntW-1:0] cnt);
    int unsigned lo = r.lo;
    int unsigned hi = r.hi;
    int unsigned n = 0;
    int unsigned blo;
    int unsigned bhi;
    cnt = '0;
    if (r.cmd == CmdLoad) begin
      if (lo < ArrayDepth) begin
        flush_tag(lo / BlockSize);
        shadow_mem[lo] = r.val;
      end
      return 1'b0;
    end
    if (hi >= ArrayDepth) hi = ArrayDepth - 1;
    if (lo <= hi) begin
      blo = lo / BlockSize;
      bhi = hi / BlockSize;
      if (blo == bhi) begin
        n = count_span(lo, hi, r.val);
      end else begin
        n += count_span(lo, blo * BlockSize + BlockSize - 1, r.val);
        for (int unsigned b = blo + 1; b < bhi; b++) begin
          // whole block: the tag answers when set, otherwise walk once
          if (shadow_tag_on[b]) begin
            if (shadow_tag_val[b] == r.val) n += BlockSize;
          end else begin
            n += count_span(b * BlockSize, b * BlockSize + BlockSize - 1, r.val);
          end
          shadow_tag_val[b] = r.val;
          shadow_tag_on[b] = 1'b1;
        end
        n += count_span(bhi * BlockSize, hi, r.val);
      end
    end
    cnt = n[CntW-1:0];
    return 1'b1;
  endfunction

  // values mostly drawn from a small pool so that ranges see real matches
  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom % 8)
      0: return 32'sd0;
      1: return -32'sd1;
      2: return 32'sh7fffffff;
      3: return 32'sh80000000;
      4, 5: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic cmd, int unsigned lo, int unsigned hi,
                         logic signed [ValW-1:0] v, bit drain);
    req_t r;
    r.cmd = cmd;
    r.lo = IdxW'(lo);
    r.hi = IdxW'(hi);
    r.val = v;
    r.drain_first = drain;
    pending_q.push_back(r);
  endtask

  task automatic add_load(int unsigned idx, logic signed [ValW-1:0] v);
    add_req(CmdLoad, idx, $urandom, v, 1'b0);
    written[idx] = 1'b1;
  endtask

  // a range never reads an element that was never written: load those first
  task automatic add_range(int unsigned lo, int unsigned hi, logic signed [ValW-1:0] v,
                           bit drain);
    if (lo <= hi) begin
      for (int unsigned i = lo; i <= hi; i++)
        if (!written[i]) add_load(i, pick_value());
      for (int unsigned i = lo; i <= hi; i++) written[i] = 1'b1;
    end
    add_req(CmdRange, lo, hi, v, drain);
  endtask

  // stimulus: directed corners, then random sequences
  initial begin
    int unsigned lo;
    int unsigned hi;
    int unsigned r;
    add_load(0, 32'sh80000000);
    add_load(ArrayDepth - 1, 32'sh7fffffff);
    add_range(0, 0, 32'sh80000000, 1'b0);              // single match at the bottom
    add_range(ArrayDepth - 1, ArrayDepth - 1, 32'sd0, 1'b0); // miss at the top
    add_range(ArrayDepth - 1, ArrayDepth - 1, 32'sd0, 1'b0); // zero written by the last range now matches
    add_req(CmdRange, 5, 3, -32'sd1, 1'b0);            // empty range
    add_req(CmdRange, ArrayDepth - 1, 0, 32'sd7, 1'b0); // empty, extreme bounds
    add_range(31, 64, 32'sd0, 1'b0);                   // two partial blocks and one whole
    add_range(32, 63, 32'sd0, 1'b0);                   // one exact block: its tag is pushed down, then walked
    add_load(40, 32'sd9);                              // load into the block whose tag was just pushed down
    add_range(32, 63, 32'sd0, 1'b0);                   // the loaded element must miss
    add_range(30, 66, -32'sd1, 1'b1);
    add_range(0, 31, 32'sh7fffffff, 1'b0);             // one exact block

    while (pending_q.size() < NumItems) begin
      r = $urandom % 100;
      if (r < 20) begin
        add_load($urandom_range(0, ArrayDepth - 1), pick_value());
      end else if (r < 25) begin
        hi = $urandom_range(0, ArrayDepth - 2);
        add_req(CmdRange, $urandom_range(hi + 1, ArrayDepth - 1), hi, pick_value(), 1'b0);
      end else begin
        lo = $urandom_range(0, ArrayDepth - 1);
        if (r < 85) hi = lo + $urandom_range(0, 70);
        else if (r < 95) hi = lo + $urandom_range(0, 300);
        else hi = lo + $urandom_range(0, ArrayDepth);
        if (hi > ArrayDepth - 1) hi = ArrayDepth - 1;
        add_range(lo, hi, pick_value(), ($urandom % 200) == 0);
      end
    end
    // finish with a full sweep, the array is mostly written by now
    add_range(0, ArrayDepth - 1, pick_value(), 1'b1);
    add_range(0, ArrayDepth - 1, pick_value(), 1'b0);
  end

  // input side: new transaction or idle burst at the falling edge
  bit          in_fire = 1'b0;
  int unsigned in_gap = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].drain_first && count_q.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        command_i <= pending_q[0].cmd;
        range_lo_i <= pending_q[0].lo;
        range_hi_i <= pending_q[0].hi;
        value_i <= pending_q[0].val;
        pending_q[0].drain_first = 1'b0;
        if (pending_q.size() > QuietTail && ($urandom % 8) == 0)
          in_gap <= $urandom_range(1, 12);
      end
    end
  end

  // output side: random stall bursts plus one long hold to back the block up
  int unsigned out_burst = 0;
  int unsigned out_hold = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (!hold_done && accepted_items >= HoldAtItem) begin
      hold_done <= 1'b1;
      out_hold <= LongHold;
      out_stall_i <= 1'b1;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_stall_i <= 1'b1;
    end else if (out_burst > 0) begin
      out_burst <= out_burst - 1;
      out_stall_i <= 1'b1;
    end else if (pending_q.size() > QuietTail && ($urandom % 6) == 0) begin
      out_burst <= $urandom_range(0, 11);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: prediction on input transactions, compare on output transactions
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    req_t            cur;
    logic [CntW-1:0] want;
    bit              took_out;
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    took_out = rst_ni && out_valid_o && !out_stall_i;
    if (in_fire) begin
      cur.cmd = command_i;
      cur.lo = range_lo_i;
      cur.hi = range_hi_i;
      cur.val = value_i;
      cur.drain_first = 1'b0;
      void'(pending_q.pop_front());
      accepted_items++;
      if (predict_count(cur, want)) count_q.push_back(want);
    end
    if (took_out) begin
      if (count_q.size() == 0) begin
        $display("%0t: unexpected count, expected none, actual %0d", $time, equal_count_o);
        errors++;
      end else begin
        want = count_q.pop_front();
        if (equal_count_o !== want) begin
          $display("%0t: equal_count mismatch, expected %0d, actual %0d",
                   $time, want, equal_count_o);
          errors++;
        end
      end
    end
    // watchdog on cycles with no transaction at all
    if (in_fire || took_out) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("range_count_equal_and_assign_tb NOT OK");
      $finish;
    end
  end

  // end of run: all sent, all counts back, then a short drain
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    while (pending_q.size() != 0 || count_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && count_q.size() == 0) begin
      $display("range_count_equal_and_assign_tb OK");
    end else begin
      $display("range_count_equal_and_assign_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rca_pkg.sv
hw/rtl/range_count_equal_and_assign.sv
sim/range_count_equal_and_assign_tb.sv
